// ===== rtl/fcdma_pkg.sv =====
// Package for the four-channel DMA controller: request codes, control-word bit
// positions, the queue entry type and the default parameter values.
// Depends on nothing.
package fcdma_pkg;

  localparam int unsigned DefChannels     = 4;
  localparam int unsigned DefVisibleLines = 160;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [1:0] {
    REQ_PROGRAM = 2'd0,
    REQ_STOP    = 2'd1,
    REQ_HBLANK  = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  localparam int unsigned CtlDestLo  = 5;
  localparam int unsigned CtlSrcLo   = 7;
  localparam int unsigned CtlRepeat  = 9;
  localparam int unsigned CtlWide    = 10;
  localparam int unsigned CtlStartLo = 12;
  localparam int unsigned CtlIrq     = 14;
  localparam int unsigned CtlEnable  = 15;

  localparam logic [1:0] StepInc    = 2'd0;
  localparam logic [1:0] StepDec    = 2'd1;
  localparam logic [1:0] StepFixed  = 2'd2;
  localparam logic [1:0] StepReload = 2'd3;

  localparam logic [1:0] StartNow    = 2'd0;
  localparam logic [1:0] StartHblank = 2'd2;

  // One classified request as handed from the front end to the sequencer.
  typedef struct packed {
    logic        hblank;
    logic [1:0]  channel;
    logic [31:0] src_addr;
    logic [31:0] dest_addr;
    logic [16:0] units;
    logic [15:0] ctrl;
  } cmd_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_EMIT
  } seq_state_e;

endpackage

// ===== rtl/fcdma_front.sv =====
// Front end: accepts requests, drops those with no effect, queues programs and hblank events and passes stops on.
// Depends on fcdma_pkg.
module fcdma_front #(
  parameter int unsigned Channels     = fcdma_pkg::DefChannels,
  parameter int unsigned VisibleLines = fcdma_pkg::DefVisibleLines
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        req_type_i,
  input  logic [1:0]        channel_i,
  input  logic [31:0]       src_addr_i,
  input  logic [31:0]       dest_addr_i,
  input  logic [31:0]       control_word_i,
  input  logic [7:0]        scan_line_i,
  output logic              busy_o,
  output logic              stop_o,
  output logic [1:0]        stop_chan_o,
  output logic              q_valid_o,
  output fcdma_pkg::cmd_t   q_cmd_o,
  input  logic              q_pop_i
);

  localparam int unsigned Qd = fcdma_pkg::QueueDepth;

  fcdma_pkg::cmd_t q_mem [Qd];
  logic            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            accept, push, chan_ok;
  fcdma_pkg::cmd_t cmd;
  logic [15:0]     cnt;

  assign busy_o  = (count_q == 2'(Qd));
  assign accept  = start_i && !busy_o;
  assign chan_ok = ({30'd0, channel_i} < Channels);

  always_comb begin
    cnt = control_word_i[15:0];
    cmd.hblank    = (req_type_i == fcdma_pkg::REQ_HBLANK);
    cmd.channel   = channel_i;
    cmd.src_addr  = src_addr_i;
    cmd.dest_addr = dest_addr_i;
    cmd.ctrl      = control_word_i[31:16];
    if (cnt != 16'd0) cmd.units = {1'b0, cnt};
    else if (channel_i == 2'd3) cmd.units = 17'h10000;
    else cmd.units = 17'h04000;
  end

  always_comb begin
    push = 1'b0;
    unique case (fcdma_pkg::req_e'(req_type_i))
      fcdma_pkg::REQ_PROGRAM: push = accept && chan_ok;
      fcdma_pkg::REQ_HBLANK:  push = accept && ({24'd0, scan_line_i} < VisibleLines);
      default:                push = 1'b0;
    endcase
  end

  assign stop_o      = accept && chan_ok && (req_type_i == fcdma_pkg::REQ_STOP);
  assign stop_chan_o = channel_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) wr_ptr_d = wr_ptr_q + 1'b1;
    if (q_pop_i) rd_ptr_d = rd_ptr_q + 1'b1;
    count_d = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd;
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_cmd_o   = q_mem[rd_ptr_q];

endmodule

// ===== rtl/fcdma_back.sv =====
// Back end: per-channel state and a sequencer that fires channels at most one a cycle
// and emits move descriptors. Depends on fcdma_pkg.
module fcdma_back #(
  parameter int unsigned Channels = fcdma_pkg::DefChannels
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            stop_i,
  input  logic [1:0]      stop_chan_i,
  input  logic            q_valid_i,
  input  fcdma_pkg::cmd_t q_cmd_i,
  output logic            q_pop_o,
  output logic            idle_o,
  output logic            done_o,
  output logic [1:0]      chan_out_o,
  output logic [31:0]     move_src_o,
  output logic [31:0]     move_dest_o,
  output logic [16:0]     move_units_o,
  output logic            wide_units_o,
  output logic [1:0]      src_step_o,
  output logic [1:0]      dest_step_o,
  output logic            irq_raise_o,
  output logic            last_o
);

  logic [31:0] reload_q [Channels];
  logic [31:0] src_q    [Channels];
  logic [31:0] dst_q    [Channels];
  logic [16:0] units_q  [Channels];
  logic [15:0] ctrl_q   [Channels];
  logic [Channels-1:0] active_q;

  fcdma_pkg::seq_state_e state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       hb_q, hb_d;
  // A fired channel is held back until the next fire or the emit state so "last" is known.
  logic       pend_q, pend_d;

  logic       load, fire, is_last, can_fire, wants;
  logic [15:0] c;
  logic [1:0]  ss, ds;
  logic [18:0] bytes;
  logic [31:0] nsrc, ndst;

  // Candidate for firing this cycle.
  always_comb begin
    c        = ctrl_q[idx_q];
    wants    = hb_q ? (c[fcdma_pkg::CtlStartLo+:2] == fcdma_pkg::StartHblank)
                    : (c[fcdma_pkg::CtlStartLo+:2] == fcdma_pkg::StartNow);
    can_fire = active_q[idx_q] && (src_q[idx_q] != 32'd0) && (dst_q[idx_q] != 32'd0);
    ss       = c[fcdma_pkg::CtlSrcLo+:2];
    if (ss == fcdma_pkg::StepReload) ss = fcdma_pkg::StepInc;
    ds       = c[fcdma_pkg::CtlDestLo+:2];
    bytes    = c[fcdma_pkg::CtlWide] ? {units_q[idx_q], 2'b00} : {1'b0, units_q[idx_q], 1'b0};
    case (ss)
      fcdma_pkg::StepDec:   nsrc = src_q[idx_q] - {13'd0, bytes};
      fcdma_pkg::StepFixed: nsrc = src_q[idx_q];
      default:              nsrc = src_q[idx_q] + {13'd0, bytes};
    endcase
    case (ds)
      fcdma_pkg::StepDec:    ndst = dst_q[idx_q] - {13'd0, bytes};
      fcdma_pkg::StepFixed:  ndst = dst_q[idx_q];
      fcdma_pkg::StepReload: ndst = reload_q[idx_q];
      default:               ndst = dst_q[idx_q] + {13'd0, bytes};
    endcase
  end

  assign is_last = !hb_q || ({30'd0, idx_q} == Channels - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcdma_pkg::SEQ_IDLE: if (q_valid_i) state_d = fcdma_pkg::SEQ_SCAN;
      fcdma_pkg::SEQ_SCAN: if (is_last) state_d = fcdma_pkg::SEQ_EMIT;
      fcdma_pkg::SEQ_EMIT: state_d = fcdma_pkg::SEQ_IDLE;
      default:             state_d = fcdma_pkg::SEQ_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    load      = 1'b0;
    fire      = 1'b0;
    q_pop_o   = 1'b0;
    idx_d     = idx_q;
    hb_d      = hb_q;
    pend_d    = pend_q;
    done_o    = 1'b0;
    unique case (state_q)
      fcdma_pkg::SEQ_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          hb_d    = q_cmd_i.hblank;
          idx_d   = q_cmd_i.hblank ? 2'd0 : q_cmd_i.channel;
          load    = !q_cmd_i.hblank;
          pend_d  = 1'b0;
        end
      end
      fcdma_pkg::SEQ_SCAN: begin
        fire = wants && can_fire;
        if (fire) begin
          done_o = pend_q;
          pend_d = 1'b1;
        end
        if (!is_last) idx_d = idx_q + 2'd1;
      end
      fcdma_pkg::SEQ_EMIT: begin
        done_o = pend_q;
        pend_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign idle_o = (state_q == fcdma_pkg::SEQ_IDLE);
  assign last_o = (state_q == fcdma_pkg::SEQ_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fcdma_pkg::SEQ_IDLE;
      idx_q     <= 2'd0;
      hb_q      <= 1'b0;
      pend_q    <= 1'b0;
      active_q  <= '0;
      for (int i = 0; i < Channels; i++) begin
        reload_q[i] <= 32'd0;
        src_q[i]    <= 32'd0;
        dst_q[i]    <= 32'd0;
        units_q[i]  <= 17'd0;
        ctrl_q[i]   <= 16'd0;
      end
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      hb_q      <= hb_d;
      pend_q    <= pend_d;
      if (load) begin
        reload_q[q_cmd_i.channel] <= q_cmd_i.dest_addr;
        src_q[q_cmd_i.channel]    <= q_cmd_i.src_addr;
        dst_q[q_cmd_i.channel]    <= q_cmd_i.dest_addr;
        units_q[q_cmd_i.channel]  <= q_cmd_i.units;
        ctrl_q[q_cmd_i.channel]   <= q_cmd_i.ctrl;
        active_q[q_cmd_i.channel] <= q_cmd_i.ctrl[fcdma_pkg::CtlEnable];
      end
      if (fire) begin
        src_q[idx_q] <= nsrc;
        dst_q[idx_q] <= ndst;
        if (!c[fcdma_pkg::CtlRepeat]) begin
          active_q[idx_q] <= 1'b0;
          ctrl_q[idx_q]   <= c & 16'h4FFF & ~16'h0200;
        end
      end
      if (stop_i) begin
        active_q[stop_chan_i] <= 1'b0;
        ctrl_q[stop_chan_i]   <= ctrl_q[stop_chan_i] & 16'h4DFF;
      end
    end
  end

  // Descriptor register, captured as a channel fires and presented with done at the next fire or in the emit state.
  logic [1:0]  d_ch_q;
  logic [31:0] d_src_q, d_dst_q;
  logic [16:0] d_units_q;
  logic        d_wide_q, d_irq_q;
  logic [1:0]  d_ss_q, d_ds_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      d_ch_q    <= idx_q;
      d_src_q   <= src_q[idx_q];
      d_dst_q   <= dst_q[idx_q];
      d_units_q <= units_q[idx_q];
      d_wide_q  <= c[fcdma_pkg::CtlWide];
      d_irq_q   <= c[fcdma_pkg::CtlIrq];
      d_ss_q    <= ss;
      d_ds_q    <= (ds == fcdma_pkg::StepReload) ? fcdma_pkg::StepInc : ds;
    end
  end

  assign chan_out_o   = d_ch_q;
  assign move_src_o   = d_src_q;
  assign move_dest_o  = d_dst_q;
  assign move_units_o = d_units_q;
  assign wide_units_o = d_wide_q;
  assign src_step_o   = d_ss_q;
  assign dest_step_o  = d_ds_q;
  assign irq_raise_o  = d_irq_q;

endmodule

// ===== rtl/four_channel_dma_controller.sv =====
// Four-channel DMA controller. The sequencer pops a request once the back end is idle;
// a program request then takes a scan and an emit state, an hblank event scans every
// channel in turn and then emits. Descriptors come at most one a cycle, strobed by
// valid_o; the receiver cannot stall. busy is high while the two-entry queue is full or
// a stop waits for the back end to drain. Reset clears the queue pointers, the sequencer
// and the channel state; the queue storage and descriptor register are not reset.
module four_channel_dma_controller #(
  parameter int unsigned Channels     = fcdma_pkg::DefChannels,
  parameter int unsigned VisibleLines = fcdma_pkg::DefVisibleLines
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [1:0]  channel_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [31:0] control_word_i,
  input  logic [7:0]  scan_line_i,
  output logic        valid_o,
  output logic [1:0]  chan_out_o,
  output logic [31:0] move_src_o,
  output logic [31:0] move_dest_o,
  output logic [16:0] move_units_o,
  output logic        wide_units_o,
  output logic [1:0]  src_step_o,
  output logic [1:0]  dest_step_o,
  output logic        irq_raise_o,
  output logic        last_o
);

  logic            q_valid, q_pop, stop, idle, done, last_raw;
  logic [1:0]      stop_chan;
  fcdma_pkg::cmd_t q_cmd;

  // Stops must not overtake queued programs, so they wait for an empty back end.
  logic busy_int, stop_hold;
  assign stop_hold = start && (req_type_i == fcdma_pkg::REQ_STOP) && (q_valid || !idle);
  assign busy = busy_int || stop_hold;

  fcdma_front #(.Channels(Channels), .VisibleLines(VisibleLines)) u_front (
    .clk_i, .rst_ni,
    .start_i(start && !stop_hold),
    .req_type_i, .channel_i, .src_addr_i, .dest_addr_i, .control_word_i, .scan_line_i,
    .busy_o(busy_int), .stop_o(stop), .stop_chan_o(stop_chan),
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  fcdma_back #(.Channels(Channels)) u_back (
    .clk_i, .rst_ni,
    .stop_i(stop), .stop_chan_i(stop_chan),
    .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .idle_o(idle), .done_o(done),
    .chan_out_o, .move_src_o, .move_dest_o, .move_units_o, .wide_units_o,
    .src_step_o, .dest_step_o, .irq_raise_o, .last_o(last_raw)
  );

  assign valid_o = done;
  assign last_o  = last_raw && done;

  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last without valid");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop |-> idle)
    else $error("stop applied while sequencer busy");

endmodule
